### rtl/rdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// shared constants, types and helpers for the radix digit converter
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int IN_VALUE_W      = 64;
  localparam int IN_RADIX_W      = 8;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 7;

  localparam logic [IN_RADIX_W-1:0] BASE_MIN     = 8'd2;
  localparam logic [IN_RADIX_W-1:0] BASE_MAX     = 8'd36;
  localparam logic [DIGIT_W-1:0]    BASE_DEFAULT = 6'd10;
  localparam logic [DIGIT_W-1:0]    DIGIT_TEN    = 6'd10;
  localparam logic [CHAR_W-1:0]     CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0]     CHAR_ALPHA   = 7'd55;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd_req;
  } rdc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic q_zero;
    logic store_last;
    logic cnt_zero;
  } rdc_sts_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DIGIT_TEN) begin
      to_ascii = CHAR_ZERO + dx;
    end else begin
      to_ascii = CHAR_ALPHA + dx;
    end
  endfunction

  function automatic logic [DIGIT_W-1:0] pick_base(input logic [IN_RADIX_W-1:0] r);
    if (r < BASE_MIN || r > BASE_MAX) begin
      pick_base = BASE_DEFAULT;
    end else begin
      pick_base = r[DIGIT_W-1:0];
    end
  endfunction

endpackage

### rtl/rdc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ctrl
// sequencer: load, bit-serial divide, digit store, most significant first emit
// ----------------------------------------------------------------------------
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  rdc_sts_t sts,
  output rdc_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_RD,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (sts.q_zero || sts.store_last) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_RD: begin
        cmd.rd_req = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

endmodule

### rtl/rdc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_datapath
// restoring divider one bit per cycle, digit memory and character encode
// ----------------------------------------------------------------------------
module rdc_datapath
  import rdc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rdc_cmd_t              cmd,
  input  logic [IN_VALUE_W-1:0] in_value,
  input  logic [IN_RADIX_W-1:0] in_radix,
  output rdc_sts_t              sts,
  output logic [CHAR_W-1:0]     out_digit_char
);

  localparam int DEPTH = VALUE_WIDTH;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int BIT_W = $clog2(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEPTH - 1);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] quo_r;
  logic [DIGIT_W-1:0]     rem_r;
  logic [DIGIT_W-1:0]     base_r;
  logic [BIT_W-1:0]       bit_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [DIGIT_W-1:0]     rd_data_r;
  logic [DIGIT_W-1:0]     mem [DEPTH];

  logic [DIGIT_W:0]       rem_sh;
  logic [DIGIT_W:0]       rem_sub;
  logic                   ge;
  logic [CNT_W-1:0]       cnt_dec;

  assign rem_sh  = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign ge      = (rem_sh >= {1'b0, base_r});
  assign rem_sub = rem_sh - {1'b0, base_r};
  assign cnt_dec = cnt_r - CNT_W'(1);

  // divider and quotient
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r  <= in_value[VALUE_WIDTH-1:0];
      base_r <= pick_base(in_radix);
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[VALUE_WIDTH-2:0], ge};
      rem_r <= ge ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
    end else if (cmd.store) begin
      rem_r <= '0;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.load || cmd.store) begin
        bit_r <= '0;
      end else if (cmd.div_step) begin
        bit_r <= bit_r + BIT_W'(1);
      end
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.store) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.rd_req) begin
        cnt_r <= cnt_dec;
      end
    end
  end

  // digit memory
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[cnt_r[IDX_W-1:0]] <= rem_r;
    end
    if (cmd.rd_req) begin
      rd_data_r <= mem[cnt_dec[IDX_W-1:0]];
    end
  end

  assign sts.div_done   = (bit_r == BIT_LAST);
  assign sts.q_zero     = (quo_r == '0);
  assign sts.store_last = (cnt_r == CNT_LAST);
  assign sts.cnt_zero   = (cnt_r == '0);

  assign out_digit_char = to_ascii(rd_data_r);

endmodule

### rtl/radix_digit_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// unsigned integer to ascii digits in base 2..36, most significant digit first
// ----------------------------------------------------------------------------
// each digit is found by bit-serial division in the one-bit-per-cycle restoring
// divider and then stored; once all digits are stored, each is emitted through
// a registered read, most significant first; one transaction at a time
// results leave as one-cycle strobes, the receiver cannot stall
// synchronous reset clears the controller and counters, digit memory is not cleared
module radix_digit_converter_top
  import rdc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [IN_VALUE_W-1:0] in_value,
  input  logic [IN_RADIX_W-1:0] in_radix,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit
);

  rdc_cmd_t cmd;
  rdc_sts_t sts;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rdc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .sts            (sts),
    .out_digit_char (out_digit_char)
  );

  assign out_last_digit = out_valid & sts.cnt_zero;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back result strobes");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_digit |=> !busy)
    else $error("not idle after last digit");

  a_store_not_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> !out_valid && !cmd.div_step)
    else $error("store overlaps divide or emit");

endmodule
